[sv/scm_pkg.sv]
`default_nettype none

package scm_pkg;

   // Field widths fixed by the word format
   localparam int IndexW = 20;
   localparam int DistW  = 32;

   // Default number of stored reverse matches
   localparam int TableDepthDefault = 1024;

   // Command codes
   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   // Input word
   typedef struct packed {
      logic [1:0]        opcode;
      logic [IndexW-1:0] query_index;
      logic [IndexW-1:0] train_index;
      logic [DistW-1:0]  distance_bits;
   } scm_req_type;

   // Result word
   typedef struct packed {
      logic              matched;
      logic [IndexW-1:0] out_query_index;
      logic [IndexW-1:0] out_train_index;
      logic [DistW-1:0]  out_distance_bits;
      logic              table_overflowed;
   } scm_rsp_type;

   // One stored reverse match: query index high, train index low
   typedef struct packed {
      logic [IndexW-1:0] query_index;
      logic [IndexW-1:0] train_index;
   } scm_entry_type;

   localparam int EntryW = $bits(scm_entry_type);

   // Scan engine status toward the command logic
   typedef struct packed {
      logic busy;
      logic done;
      logic hit;
   } scm_scan_status_type;

endpackage

`default_nettype wire

[sv/scm_ram.sv]
`default_nettype none

module scm_ram #(
   parameter int  WIDTH = 40,
   parameter int  DEPTH = 1024,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

[sv/scm_scan.sv]
`default_nettype none

module scm_scan import scm_pkg::*; #(
   parameter int  TABLE_DEPTH = TableDepthDefault,
   localparam int AddrW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
   localparam int CountW = $clog2(TABLE_DEPTH + 1)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start_scan,
   input  wire logic [CountW-1:0]   fill_count,
   input  wire logic [IndexW-1:0]   key_query,
   input  wire logic [IndexW-1:0]   key_train,
   output logic                     rd_en,
   output logic      [AddrW-1:0]    rd_addr,
   input  wire scm_entry_type       rd_data,
   output scm_scan_status_type      status
);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type         state_ff;
   logic [AddrW-1:0]  addr_ff;
   logic              issue_ff;
   logic              cmp_valid_ff;
   logic              last_ff;
   logic              done_ff;
   logic              hit_ff;

   logic              addr_is_last;
   logic              entry_match;

   // Address of the final stored entry reached
   assign addr_is_last = (CountW'(addr_ff) + CountW'(1)) == fill_count;

   // Symmetric test: stored train equals forward query, and the reverse
   assign entry_match = (rd_data.train_index == key_query) &&
                        (rd_data.query_index == key_train);

   assign rd_en   = issue_ff;
   assign rd_addr = addr_ff;

   assign status.busy = (state_ff == ST_SCAN);
   assign status.done = done_ff;
   assign status.hit  = hit_ff;

   // Sequencer: one read issued and one entry compared per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         addr_ff      <= '0;
         issue_ff     <= 1'b0;
         cmp_valid_ff <= 1'b0;
         last_ff      <= 1'b0;
         done_ff      <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start_scan) begin
                  if (fill_count == '0) begin
                     // empty table answers at once
                     done_ff <= 1'b1;
                     hit_ff  <= 1'b0;
                  end else begin
                     state_ff     <= ST_SCAN;
                     addr_ff      <= '0;
                     issue_ff     <= 1'b1;
                     cmp_valid_ff <= 1'b0;
                  end
               end
            end
            ST_SCAN: begin
               if (issue_ff) begin
                  cmp_valid_ff <= 1'b1;
                  last_ff      <= addr_is_last;
                  issue_ff     <= !addr_is_last;
                  if (!addr_is_last) begin
                     addr_ff <= addr_ff + AddrW'(1);
                  end
               end else begin
                  cmp_valid_ff <= 1'b0;
               end
               // first hit or end of table closes the scan
               if (cmp_valid_ff && (entry_match || last_ff)) begin
                  done_ff      <= 1'b1;
                  hit_ff       <= entry_match;
                  state_ff     <= ST_IDLE;
                  issue_ff     <= 1'b0;
                  cmp_valid_ff <= 1'b0;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

[sv/symmetric_match_cross_check.sv]
`default_nettype none

// Symmetric match cross-check. A word is taken when start is high and busy
// is low. Clear and load words give no result; a load into a full table is
// dropped and sets the overflow flag until the next clear. A query word
// scans the stored entries in load order, one entry per cycle through the
// single read port of the table RAM, and stops at the first symmetric
// partner; a query to an empty table is answered without a scan. Busy is
// high for the scan. Each result is on rsp_item for exactly one cycle with
// rsp_strobe high; the receiver cannot stall it, so it must take every
// result in that cycle. table_overflowed reports the flag as it stood when
// the query was taken.
module symmetric_match_cross_check import scm_pkg::*; #(
   parameter int TABLE_DEPTH = TableDepthDefault
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire scm_req_type  req_item,
   output logic              rsp_strobe,
   output scm_rsp_type       rsp_item
);

   localparam int AddrW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CountW = $clog2(TABLE_DEPTH + 1);

   logic [CountW-1:0]   fill_count_ff, fill_count_in;
   logic                overflow_ff, overflow_in;
   logic [IndexW-1:0]   key_query_ff, key_query_in;
   logic [IndexW-1:0]   key_train_ff, key_train_in;
   logic [DistW-1:0]    key_dist_ff, key_dist_in;

   logic                accept;
   logic                table_full;
   logic                wr_en;
   logic                start_scan;
   logic                rd_en;
   logic [AddrW-1:0]    rd_addr;
   scm_entry_type       wr_entry;
   scm_entry_type       rd_entry;
   scm_scan_status_type scan_status;

   assign accept     = start && !busy;
   assign table_full = (fill_count_ff == CountW'(TABLE_DEPTH));
   assign busy       = scan_status.busy;

   assign wr_entry.query_index = req_item.query_index;
   assign wr_entry.train_index = req_item.train_index;

   // Command decode
   always_comb begin
      fill_count_in = fill_count_ff;
      overflow_in   = overflow_ff;
      key_query_in  = key_query_ff;
      key_train_in  = key_train_ff;
      key_dist_in   = key_dist_ff;
      wr_en         = 1'b0;
      start_scan    = 1'b0;
      if (accept) begin
         unique case (req_item.opcode)
            OP_CLEAR: begin
               fill_count_in = '0;
               overflow_in   = 1'b0;
            end
            OP_LOAD: begin
               if (table_full) begin
                  overflow_in = 1'b1;
               end else begin
                  wr_en         = 1'b1;
                  fill_count_in = fill_count_ff + CountW'(1);
               end
            end
            OP_QUERY: begin
               key_query_in = req_item.query_index;
               key_train_in = req_item.train_index;
               key_dist_in  = req_item.distance_bits;
               start_scan   = 1'b1;
            end
            default: begin
               // unused code: ignored
            end
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff <= '0;
         overflow_ff   <= 1'b0;
      end else begin
         fill_count_ff <= fill_count_in;
         overflow_ff   <= overflow_in;
      end
   end

   // Query key, held through the scan and the result cycle
   always_ff @(posedge clock) begin
      key_query_ff <= key_query_in;
      key_train_ff <= key_train_in;
      key_dist_ff  <= key_dist_in;
   end

   scm_ram #(
      .WIDTH (EntryW),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_count_ff[AddrW-1:0]),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   scm_scan #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .start_scan (start_scan),
      .fill_count (fill_count_ff),
      .key_query  (key_query_ff),
      .key_train  (key_train_ff),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_entry),
      .status     (scan_status)
   );

   // Result word; index and distance fields are zero when no partner was found
   assign rsp_strobe                 = scan_status.done;
   assign rsp_item.matched           = scan_status.hit;
   assign rsp_item.out_query_index   = scan_status.hit ? key_query_ff : '0;
   assign rsp_item.out_train_index   = scan_status.hit ? key_train_ff : '0;
   assign rsp_item.out_distance_bits = scan_status.hit ? key_dist_ff : '0;
   assign rsp_item.table_overflowed  = overflow_ff;

   // A result is only shown once the scan has let go of the block
   a_rsp_not_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while scan still busy");

   // A query either starts a scan or answers at once
   a_query_progress : assert property (@(posedge clock) disable iff (reset)
      (accept && req_item.opcode == OP_QUERY) |=> (busy || rsp_strobe))
      else $error("query taken without scan or result");

   // Fill count never passes the table size
   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= CountW'(TABLE_DEPTH))
      else $error("fill count beyond table depth");

   // A clear empties the table and drops the overflow flag
   a_clear : assert property (@(posedge clock) disable iff (reset)
      (accept && req_item.opcode == OP_CLEAR) |=> (fill_count_ff == '0 && !overflow_ff))
      else $error("clear did not empty the table");

endmodule

`default_nettype wire
